// ===== design/ple_pkg.sv =====
// Shared constants and types for the positional list engine.
package ple_pkg;

    localparam int CAPACITY   = 256;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 9;
    localparam int OPC_W      = 3;
    localparam int COUNT_W    = 9;
    localparam int STATUS_W   = 3;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int IN_TDATA_W  = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

    localparam logic [OPC_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OPC_W-1:0] OP_DELETE  = 3'd1;
    localparam logic [OPC_W-1:0] OP_READ    = 3'd2;
    localparam logic [OPC_W-1:0] OP_APPEND  = 3'd3;
    localparam logic [OPC_W-1:0] OP_POP     = 3'd4;
    localparam logic [OPC_W-1:0] OP_DEQUEUE = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_BEYOND = 3'd1,
        ST_BELOW  = 3'd2,
        ST_FULL   = 3'd3,
        ST_EMPTY  = 3'd4
    } status_t;

endpackage

// ===== design/positional_list_engine.sv =====
// Top level of the positional list engine: list control around one entry RAM.
// From accept to m_tvalid: errors and spare opcodes go straight to the result; read, pop,
// append and tail insert take one RAM access first; insert moves entries up from the tail
// and delete or dequeue close the gap toward the head, one RAM move per cycle. One item at
// a time: next accept in the cycle after the result loads, later while m_tready stalls.
// Reset (rst_n low, async) empties the list; entry RAM contents are not cleared.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // position [8:0], value [40:9], zero pad
    input  logic [OPC_W-1:0]       s_tuser,   // opcode [2:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // data_out [31:0], count [40:32], zero pad
    output logic [STATUS_W-1:0]    m_tuser    // status [2:0]
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RDWAIT = 7'b0000010,
        S_INS    = 7'b0000100,
        S_PUT    = 7'b0001000,
        S_DELH   = 7'b0010000,
        S_DEL    = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    status_t             res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_data_reg, res_data_next;
    logic [CNT_W-1:0]    res_count_reg, res_count_next;
    logic                m_tvalid_reg, m_tvalid_next;
    status_t             out_status_reg, out_status_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [DATA_W-1:0]   ram_wr_data;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    logic [OPC_W-1:0]    in_opcode;
    logic [POS_W-1:0]    in_position;
    logic [DATA_W-1:0]   in_value;
    logic [CMP_W-1:0]    pos_c;
    logic [CMP_W-1:0]    cnt_c;
    logic [IDX_W-1:0]    pos_idx;
    logic [IDX_W-1:0]    tail_idx;
    logic [IDX_W-1:0]    last_idx;
    logic                accept;
    logic                out_free;

    assign in_opcode   = s_tuser;
    assign in_position = s_tdata[POS_W-1:0];
    assign in_value    = s_tdata[POS_W +: DATA_W];

    assign pos_c    = CMP_W'(in_position);
    assign cnt_c    = CMP_W'(count_reg);
    assign pos_idx  = IDX_W'(in_position - POS_W'(1));
    assign tail_idx = IDX_W'(count_reg);
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    ple_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_count_next  = res_count_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = ptr_reg;
        ram_wr_data     = ram_rd_data;
        ram_rd_addr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_data_next   = '0;
                    res_count_next  = count_reg;
                    val_next        = in_value;
                    state_next      = S_DONE;
                    unique case (in_opcode)
                        OP_INSERT, OP_APPEND:
                        begin
                            if (in_opcode == OP_INSERT && pos_c > cnt_c + CMP_W'(1))
                            begin
                                res_status_next = ST_BEYOND;
                            end
                            else if (in_opcode == OP_INSERT && in_position == '0)
                            begin
                                res_status_next = ST_BELOW;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                idx_next       = (in_opcode == OP_INSERT) ? pos_idx : tail_idx;
                                res_count_next = count_reg + CNT_W'(1);
                                if (idx_next == tail_idx)
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    // move entries up from the tail, one per cycle
                                    ptr_next    = tail_idx;
                                    ram_rd_addr = tail_idx - IDX_W'(1);
                                    state_next  = S_INS;
                                end
                            end
                        end
                        OP_DELETE, OP_READ:
                        begin
                            if (pos_c > cnt_c)
                            begin
                                res_status_next = ST_BEYOND;
                            end
                            else if (in_position == '0)
                            begin
                                res_status_next = ST_BELOW;
                            end
                            else
                            begin
                                ram_rd_addr = pos_idx;
                                ptr_next    = pos_idx;
                                if (in_opcode == OP_READ)
                                begin
                                    state_next = S_RDWAIT;
                                end
                                else
                                begin
                                    res_count_next = count_reg - CNT_W'(1);
                                    state_next     = S_DELH;
                                end
                            end
                        end
                        OP_POP, OP_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next       = (in_opcode == OP_POP) ? last_idx : '0;
                                ram_rd_addr    = ptr_next;
                                res_count_next = count_reg - CNT_W'(1);
                                state_next     = S_DELH;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                res_data_next = ram_rd_data;
                state_next    = S_DONE;
            end
            S_INS:
            begin
                // read data holds entry ptr-1
                ram_wr_en   = 1'b1;
                ram_wr_addr = ptr_reg;
                ram_wr_data = ram_rd_data;
                if (ptr_reg - IDX_W'(1) == idx_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ram_rd_addr = ptr_reg - IDX_W'(2);
                    ptr_next    = ptr_reg - IDX_W'(1);
                end
            end
            S_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg;
                ram_wr_data = val_reg;
                state_next  = S_DONE;
            end
            S_DELH:
            begin
                res_data_next = ram_rd_data;
                if (CNT_W'(ptr_reg) + CNT_W'(1) < count_reg)
                begin
                    ram_rd_addr = ptr_reg + IDX_W'(1);
                    state_next  = S_DEL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DEL:
            begin
                // read data holds entry ptr+1; close the gap toward the head
                ram_wr_en   = 1'b1;
                ram_wr_addr = ptr_reg;
                ram_wr_data = ram_rd_data;
                if (CNT_W'(ptr_reg) + CNT_W'(2) < count_reg)
                begin
                    ram_rd_addr = ptr_reg + IDX_W'(2);
                    ptr_next    = ptr_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    out_count_next  = COUNT_W'(res_count_reg);
                    count_next      = res_count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        idx_reg        <= idx_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_TDATA_W'({out_count_reg, out_data_reg});

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> CNT_W'(ram_wr_addr) <= count_reg)
        else $error("RAM write outside the list");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("finished item not delivered");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg != ST_OK) |-> out_data_reg == '0)
        else $error("failed request returned data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg == ST_FULL) |-> out_count_reg == COUNT_W'(CAPACITY))
        else $error("full status with list not full");
`endif

endmodule

// ===== design/ple_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
